// ----- rtl/cosine_similarity_stream_top_defines.svh -----
// ----------------------------------------------------------------------------
// Cosine similarity stream: assertion macros
// Shared property wrappers; define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef COSINE_SIMILARITY_STREAM_TOP_DEFINES_SVH
`define COSINE_SIMILARITY_STREAM_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/cssim_pkg.sv -----
// ----------------------------------------------------------------------------
// Cosine similarity stream: shared package
// Widths, saturation limits and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package cssim_pkg;

   localparam int ELEM_BITS    = 16;
   localparam int FIELD_BITS   = 16;
   localparam int DOT_BITS     = 43;
   localparam int NORM_BITS    = 41;
   localparam int Q_BITS       = 16;
   localparam int ROOT_BITS    = 16;
   localparam int BIT_W        = $clog2(ROOT_BITS);
   localparam int MUL_W        = 2 * DOT_BITS;
   localparam int MUL_CNT_BITS = $clog2(DOT_BITS);
   localparam int R_SHIFT      = 2 * (ROOT_BITS - 1);
   localparam int SRCH_W       = MUL_W + R_SHIFT;

   localparam logic [ROOT_BITS-1:0] POS_MAX = ROOT_BITS'(32767);
   localparam logic [ROOT_BITS-1:0] NEG_CAP = ROOT_BITS'(32768);

   typedef struct packed {
      logic acc_en;
      logic snap;
      logic mul_step;
      logic load_r;
      logic srch_init;
      logic srch_a;
      logic srch_b;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic zero_norm;
      logic mul_last;
      logic bit_zero;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/cosine_similarity_stream_top.sv -----
// ----------------------------------------------------------------------------
// Cosine similarity stream: top level
// Dot product and squared norms of two signed vectors, one element pair per
// word, and a signed Q1.15 cosine on the word marked last.
//
//   channel | dir | tdata (low bit up)        | tuser     | tlast
//   req     | in  | elem_a[15:0] elem_b[31:16]| -         | last pair
//   rsp     | out | cosine_q15[15:0]          | zero_norm | -
//
// A word without tlast is only accumulated. The word with tlast then runs two
// 43-step shift-add products and a 16-bit root search, one bit per SA/SB state
// pair, or skips both when a norm is zero; req_tready is low meanwhile.
// The result sits in an output register, so a stalled rsp side only blocks
// the next result. Synchronous reset clears the accumulators and control.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cosine_similarity_stream_top_defines.svh"

module cosine_similarity_stream_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // elem_a [15:0], elem_b [31:16]
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // cosine_q15 [15:0]
   output logic        rsp_tuser    // zero_norm [0]
);

   cssim_pkg::cmd_type    cmd;
   cssim_pkg::status_type status;
   logic signed [cssim_pkg::Q_BITS-1:0] cosine_q15;

   cssim_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cssim_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .elem_a     (req_tdata[cssim_pkg::FIELD_BITS-1:0]),
      .elem_b     (req_tdata[2*cssim_pkg::FIELD_BITS-1:cssim_pkg::FIELD_BITS]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .cosine_q15 (cosine_q15),
      .zero_norm  (rsp_tuser)
   );

   assign rsp_tdata = cosine_q15;

   `ASSERT_IMPLY(a_zero_res, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   `ASSERT_NEXT(a_last_blocks, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready)
   `ASSERT_IMPLY(a_load_free, clock, reset, cmd.out_load, !rsp_tvalid || rsp_tready)

endmodule

`default_nettype wire

// ----- rtl/cssim_ctrl.sv -----
// ----------------------------------------------------------------------------
// Cosine similarity stream: controller
// Sequences accumulation, the two shift-add products, the root search and
// the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cssim_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   input  wire                     req_tlast,
   output logic                    req_tready,
   input  cssim_pkg::status_type   status,
   output cssim_pkg::cmd_type      cmd
);

   typedef enum logic [8:0] {
      ST_ACC   = 9'b000000001,
      ST_PREP  = 9'b000000010,
      ST_MULP  = 9'b000000100,
      ST_LDR   = 9'b000001000,
      ST_MULR  = 9'b000010000,
      ST_SINIT = 9'b000100000,
      ST_SA    = 9'b001000000,
      ST_SB    = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_ACC);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.acc_en = accept;
      case (state_ff)
         ST_ACC: begin
            if (accept && req_tlast) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.snap = 1'b1;
            state_in = status.zero_norm ? ST_DONE : ST_MULP;
         end
         ST_MULP: begin
            cmd.mul_step = 1'b1;
            if (status.mul_last) begin
               state_in = ST_LDR;
            end
         end
         ST_LDR: begin
            cmd.load_r = 1'b1;
            state_in   = ST_MULR;
         end
         ST_MULR: begin
            cmd.mul_step = 1'b1;
            if (status.mul_last) begin
               state_in = ST_SINIT;
            end
         end
         ST_SINIT: begin
            cmd.srch_init = 1'b1;
            state_in      = ST_SA;
         end
         ST_SA: begin
            cmd.srch_a = 1'b1;
            state_in   = ST_SB;
         end
         ST_SB: begin
            cmd.srch_b = 1'b1;
            state_in   = status.bit_zero ? ST_DONE : ST_SA;
         end
         ST_DONE: begin
            // hold until the output register can take the word
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACC;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cssim_dp.sv -----
// ----------------------------------------------------------------------------
// Cosine similarity stream: datapath
// Multiply-accumulators, a shared shift-add multiplier, a bit-by-bit root
// search and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cssim_dp (
   input  wire                                          clock,
   input  wire                                          reset,
   input  cssim_pkg::cmd_type                           cmd,
   output cssim_pkg::status_type                        status,
   input  wire signed [cssim_pkg::FIELD_BITS-1:0]       elem_a,
   input  wire signed [cssim_pkg::FIELD_BITS-1:0]       elem_b,
   input  wire                                          rsp_tready,
   output logic                                         rsp_tvalid,
   output logic signed [cssim_pkg::Q_BITS-1:0]          cosine_q15,
   output logic                                         zero_norm
);

   // accumulators
   logic signed [cssim_pkg::ELEM_BITS-1:0]   ea, eb;
   logic signed [2*cssim_pkg::ELEM_BITS-1:0] p_ab, p_aa, p_bb;
   logic [cssim_pkg::DOT_BITS-1:0]  dot_acc_ff, dot_acc_in;
   logic [cssim_pkg::NORM_BITS-1:0] norm_a_acc_ff, norm_a_acc_in;
   logic [cssim_pkg::NORM_BITS-1:0] norm_b_acc_ff, norm_b_acc_in;

   // snapshot
   logic [cssim_pkg::DOT_BITS-1:0] mag_ff, mag_in;
   logic neg_ff, neg_in, zero_ff, zero_in;

   // shift-add multiplier
   logic [cssim_pkg::MUL_W-1:0]        mcand_ff, mcand_in, prod_ff, prod_in;
   logic [cssim_pkg::DOT_BITS-1:0]     mplier_ff, mplier_in;
   logic [cssim_pkg::MUL_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [cssim_pkg::MUL_W-1:0]        p_ff, p_in;

   // root search
   logic [cssim_pkg::SRCH_W-1:0] r_ff, r_in, s_ff, s_in, u_ff, u_in, v_ff, v_in;
   logic [cssim_pkg::SRCH_W-1:0] tmp_ff, tmp_in, cand;
   logic                         fit;
   logic [cssim_pkg::ROOT_BITS-1:0] k_ff, k_in;
   logic [cssim_pkg::BIT_W-1:0]     bit_ff, bit_in;

   // output register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [cssim_pkg::Q_BITS-1:0]        res_ff, res_in;
   logic                                flag_ff, flag_in;
   logic [cssim_pkg::ROOT_BITS-1:0]     kc;
   logic [cssim_pkg::Q_BITS-1:0]        res_calc;

   assign ea   = elem_a[cssim_pkg::ELEM_BITS-1:0];
   assign eb   = elem_b[cssim_pkg::ELEM_BITS-1:0];
   assign p_ab = ea * eb;
   assign p_aa = ea * ea;
   assign p_bb = eb * eb;

   assign cand = tmp_ff + v_ff;
   assign fit  = (cand <= r_ff);

   assign status.zero_norm = (norm_a_acc_ff == '0) || (norm_b_acc_ff == '0);
   assign status.mul_last  = (cnt_ff == cssim_pkg::MUL_CNT_BITS'(cssim_pkg::DOT_BITS - 1));
   assign status.bit_zero  = (bit_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      kc = '0;
      if (zero_ff) begin
         res_calc = '0;
      end else if (neg_ff) begin
         kc       = (k_ff > cssim_pkg::NEG_CAP) ? cssim_pkg::NEG_CAP : k_ff;
         res_calc = cssim_pkg::Q_BITS'(-kc);
      end else begin
         res_calc = cssim_pkg::Q_BITS'((k_ff > cssim_pkg::POS_MAX) ? cssim_pkg::POS_MAX : k_ff);
      end
   end

   always_comb begin
      dot_acc_in    = dot_acc_ff;
      norm_a_acc_in = norm_a_acc_ff;
      norm_b_acc_in = norm_b_acc_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      zero_in   = zero_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      cnt_in    = cnt_ff;
      p_in      = p_ff;
      r_in      = r_ff;
      s_in      = s_ff;
      u_in      = u_ff;
      v_in      = v_ff;
      tmp_in    = tmp_ff;
      k_in      = k_ff;
      bit_in    = bit_ff;
      res_in    = res_ff;
      flag_in   = flag_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.acc_en) begin
         dot_acc_in    = dot_acc_ff + cssim_pkg::DOT_BITS'(p_ab);
         norm_a_acc_in = norm_a_acc_ff + cssim_pkg::NORM_BITS'($unsigned(p_aa));
         norm_b_acc_in = norm_b_acc_ff + cssim_pkg::NORM_BITS'($unsigned(p_bb));
      end

      if (cmd.snap) begin
         neg_in    = dot_acc_ff[cssim_pkg::DOT_BITS-1];
         mag_in    = dot_acc_ff[cssim_pkg::DOT_BITS-1] ? (~dot_acc_ff + 1'b1) : dot_acc_ff;
         zero_in   = status.zero_norm;
         mcand_in  = cssim_pkg::MUL_W'(norm_a_acc_ff);
         mplier_in = cssim_pkg::DOT_BITS'(norm_b_acc_ff);
         prod_in   = '0;
         cnt_in    = '0;
         // clear for the next vector pair
         dot_acc_in    = '0;
         norm_a_acc_in = '0;
         norm_b_acc_in = '0;
      end

      if (cmd.mul_step) begin
         if (mplier_ff[0]) begin
            prod_in = prod_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
      end

      if (cmd.load_r) begin
         p_in      = prod_ff;
         mcand_in  = cssim_pkg::MUL_W'(mag_ff);
         mplier_in = mag_ff;
         prod_in   = '0;
         cnt_in    = '0;
      end

      // U tracks P*k << (bit+1), V tracks P << 2*bit
      if (cmd.srch_init) begin
         r_in   = cssim_pkg::SRCH_W'(prod_ff) << cssim_pkg::R_SHIFT;
         v_in   = cssim_pkg::SRCH_W'(p_ff) << cssim_pkg::R_SHIFT;
         s_in   = '0;
         u_in   = '0;
         k_in   = '0;
         bit_in = cssim_pkg::BIT_W'(cssim_pkg::ROOT_BITS - 1);
      end

      if (cmd.srch_a) begin
         tmp_in = s_ff + u_ff;
      end

      if (cmd.srch_b) begin
         if (fit) begin
            s_in = cand;
            u_in = (u_ff + (v_ff << 1)) >> 1;
            k_in = k_ff | (cssim_pkg::ROOT_BITS'(1) << bit_ff);
         end else begin
            u_in = u_ff >> 1;
         end
         v_in   = v_ff >> 2;
         bit_in = bit_ff - 1'b1;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         res_in       = res_calc;
         flag_in      = zero_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_acc_ff    <= '0;
         norm_a_acc_ff <= '0;
         norm_b_acc_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         dot_acc_ff    <= dot_acc_in;
         norm_a_acc_ff <= norm_a_acc_in;
         norm_b_acc_ff <= norm_b_acc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      zero_ff   <= zero_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      cnt_ff    <= cnt_in;
      p_ff      <= p_in;
      r_ff      <= r_in;
      s_ff      <= s_in;
      u_ff      <= u_in;
      v_ff      <= v_in;
      tmp_ff    <= tmp_in;
      k_ff      <= k_in;
      bit_ff    <= bit_in;
      res_ff    <= res_in;
      flag_ff   <= flag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign cosine_q15 = res_ff;
   assign zero_norm  = flag_ff;

endmodule

`default_nettype wire

// ----- test/cosine_similarity_stream_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cosine similarity stream: testbench
// Streams element pairs of random and hand-picked vectors into the block and
// compares every Q1.15 cosine word and zero-norm flag with a bit-exact
// predictor kept in step with the accepted input words. Both stream sides idle
// at random, the result side once holds off long enough to back the block up,
// and the input side twice waits for all results before going on.
// ----------------------------------------------------------------------------

module cosine_similarity_stream_top_tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 150;
   localparam int LONG_HOLD      = 700;
   localparam int HOLD_AT_RESULT = 25;
   localparam int RANDOM_WORDS   = 530;

   typedef enum int {
      ELEM_FULL, ELEM_SMALL, ELEM_EXTREME, ELEM_ZERO, ELEM_MIXED
   } elem_kind_type;
   typedef enum int {
      VEC_INDEP, VEC_SAME, VEC_OPPOSITE, VEC_NEAR, VEC_ZERO_A, VEC_ZERO_B
   } vec_shape_type;

   typedef struct packed {
      logic signed [15:0] cosine;
      logic               zero_norm;
   } cosine_word_type;

   typedef struct {
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic               last;
      int unsigned        gap;
      bit                 drain;
   } pair_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // elem_a [15:0], elem_b [31:16]
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // cosine_q15 [15:0]
   logic        rsp_tuser;        // zero_norm [0]

   cosine_similarity_stream_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   pair_word_type   pairs_pending[$];
   cosine_word_type cosine_expected[$];

   logic signed [cssim_pkg::DOT_BITS-1:0] dot_sum = '0;
   logic [cssim_pkg::NORM_BITS-1:0]       norm_a_sum = '0;
   logic [cssim_pkg::NORM_BITS-1:0]       norm_b_sum = '0;

   int fail_count      = 0;
   int words_sent      = 0;
   int vectors_queued  = 0;
   int results_seen    = 0;
   int zero_norm_seen  = 0;
   int full_scale_seen = 0;

   // Cosine of the accumulated sums: largest k with k^2*na*nb <= dot^2*2^30.
   function automatic cosine_word_type cosine_of(
         logic signed [cssim_pkg::DOT_BITS-1:0] dot,
         logic [cssim_pkg::NORM_BITS-1:0] na,
         logic [cssim_pkg::NORM_BITS-1:0] nb);
      logic [cssim_pkg::DOT_BITS-1:0] mag;
      logic [127:0]        rhs;
      logic [127:0]        prod;
      logic [127:0]        lhs;
      logic [15:0]         k;
      logic [15:0]         t;
      logic [15:0]         capped;
      cosine_word_type     r;
      r = '0;
      if (na == '0 || nb == '0) begin
         r.zero_norm = 1'b1;
         return r;
      end
      mag  = dot[cssim_pkg::DOT_BITS-1] ? -dot : dot;
      rhs  = (128'(mag) * 128'(mag)) << 30;
      prod = 128'(na) * 128'(nb);
      k    = '0;
      for (int i = 15; i >= 0; i--) begin
         t   = k | (16'd1 << i);
         lhs = prod * 128'(t) * 128'(t);
         if (lhs <= rhs)
            k = t;
      end
      if (dot[cssim_pkg::DOT_BITS-1]) begin
         capped   = (k > cssim_pkg::NEG_CAP) ? cssim_pkg::NEG_CAP : k;
         r.cosine = -capped;
      end else begin
         r.cosine = (k > cssim_pkg::POS_MAX) ? cssim_pkg::POS_MAX : k;
      end
      return r;
   endfunction

   task automatic accumulate_pair(pair_word_type w);
      logic signed [31:0] prod_ab;
      logic signed [31:0] prod_aa;
      logic signed [31:0] prod_bb;
      prod_ab    = w.a * w.b;
      prod_aa    = w.a * w.a;
      prod_bb    = w.b * w.b;
      dot_sum    = dot_sum + prod_ab;
      norm_a_sum = norm_a_sum + $unsigned(prod_aa);
      norm_b_sum = norm_b_sum + $unsigned(prod_bb);
      if (w.last) begin
         cosine_expected.push_back(cosine_of(dot_sum, norm_a_sum, norm_b_sum));
         dot_sum    = '0;
         norm_a_sum = '0;
         norm_b_sum = '0;
      end
   endtask

   // Mostly back-to-back, some short gaps, a few long ones.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [15:0] draw_elem(elem_kind_type kind);
      case (kind)
         ELEM_FULL:  return 16'($urandom);
         ELEM_SMALL: return 16'(int'($urandom_range(0, 16)) - 8);
         ELEM_EXTREME: begin
            case ($urandom_range(0, 4))
               0:       return -16'sd32768;
               1:       return 16'sd32767;
               2:       return -16'sd1;
               3:       return 16'sd1;
               default: return -16'sd32767;
            endcase
         end
         default: return '0;
      endcase
   endfunction

   task automatic push_pair(logic signed [15:0] a, logic signed [15:0] b, logic last,
                            int unsigned gap, bit drain);
      pair_word_type w;
      w.a     = a;
      w.b     = b;
      w.last  = last;
      w.gap   = gap;
      w.drain = drain;
      pairs_pending.push_back(w);
   endtask

   task automatic add_vector(int len, vec_shape_type shape, elem_kind_type kind, bit burst,
                             bit drain_first);
      logic signed [15:0] a;
      logic signed [15:0] b;
      elem_kind_type      k;
      for (int i = 0; i < len; i++) begin
         k = kind;
         if (kind == ELEM_MIXED)
            k = elem_kind_type'($urandom_range(ELEM_FULL, ELEM_ZERO));
         a = draw_elem(k);
         case (shape)
            VEC_SAME:     b = a;
            VEC_OPPOSITE: b = -a;
            VEC_NEAR:     b = a + draw_elem(ELEM_SMALL);
            VEC_ZERO_A: begin
               a = '0;
               b = draw_elem(k);
            end
            VEC_ZERO_B:   b = '0;
            default:      b = draw_elem(k);
         endcase
         push_pair(a, b, i == len - 1, burst ? 0 : pick_gap(), drain_first && i == 0);
      end
      vectors_queued++;
   endtask

   // Driver: offer the head of the pending queue after its gap.
   bit          offering  = 1'b0;
   bit          gap_armed = 1'b0;
   int unsigned gap_left  = 0;

   always @(posedge clock) begin
      if (reset) begin
         offering   = 1'b0;
         gap_armed  = 1'b0;
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            accumulate_pair(pairs_pending[0]);
            pairs_pending.pop_front();
            words_sent++;
            offering = 1'b0;
         end
         if (!offering && pairs_pending.size() != 0) begin
            if (!gap_armed) begin
               gap_left  = pairs_pending[0].gap;
               gap_armed = 1'b1;
            end
            if (gap_left > 0) begin
               gap_left--;
            end else if (!pairs_pending[0].drain || cosine_expected.size() == 0) begin
               // hold a drain word back until every result is home
               offering  = 1'b1;
               gap_armed = 1'b0;
               req_tdata <= {pairs_pending[0].b, pairs_pending[0].a};
               req_tlast <= pairs_pending[0].last;
            end
         end
         req_tvalid <= offering;
      end
   end

   // Monitor: check each result word and pace rsp_tready.
   bit ready_now      = 1'b0;
   int phase_left     = 0;
   bit long_hold_done = 1'b0;

   always @(posedge clock) begin
      cosine_word_type exp_word;
      if (reset) begin
         ready_now  = 1'b0;
         phase_left = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (rsp_tuser)
               zero_norm_seen++;
            if (rsp_tdata == cssim_pkg::POS_MAX || rsp_tdata == cssim_pkg::NEG_CAP)
               full_scale_seen++;
            if (cosine_expected.size() == 0) begin
               $display("%0t: unexpected result word: cosine %0d zero_norm %0b",
                        $time, $signed(rsp_tdata), rsp_tuser);
               fail_count++;
            end else begin
               exp_word = cosine_expected.pop_front();
               if (rsp_tdata !== exp_word.cosine) begin
                  $display("%0t: cosine mismatch: expected %0d, actual %0d",
                           $time, exp_word.cosine, $signed(rsp_tdata));
                  fail_count++;
               end
               if (rsp_tuser !== exp_word.zero_norm) begin
                  $display("%0t: zero_norm mismatch: expected %0b, actual %0b",
                           $time, exp_word.zero_norm, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (results_seen == HOLD_AT_RESULT && !long_hold_done) begin
            // back the block up while the sender keeps going
            long_hold_done = 1'b1;
            ready_now      = 1'b0;
            phase_left     = LONG_HOLD;
         end else if (phase_left > 0) begin
            phase_left--;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  ready_now  = 1'b1;
                  phase_left = $urandom_range(1, 20);
               end
               6, 7, 8: begin
                  ready_now  = 1'b0;
                  phase_left = $urandom_range(1, 3);
               end
               default: begin
                  ready_now  = 1'b0;
                  phase_left = $urandom_range(8, 40);
               end
            endcase
         end
         rsp_tready <= ready_now;
      end
   end

   // Watchdog: end the run if nothing moves on either side for too long.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("cosine_similarity_stream_top verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int            random_words;
      int            len;
      int unsigned   r;
      vec_shape_type shape;
      elem_kind_type kind;
      bit            burst;
      bit            drain_next;

      // Directed: full scale, opposite signs, zero norms, orthogonal, mid values.
      push_pair(-16'sd32768, -16'sd32768, 1'b1, 0, 1'b0);
      push_pair(16'sd32767, 16'sd32767, 1'b1, 0, 1'b0);
      push_pair(-16'sd32768, 16'sd32767, 1'b1, 0, 1'b0);
      push_pair(16'sd32767, -16'sd32768, 1'b1, 1, 1'b0);
      push_pair(-16'sd1, 16'sd1, 1'b1, 0, 1'b0);
      push_pair(16'sd0, 16'sd0, 1'b1, 0, 1'b0);
      push_pair(16'sd0, -16'sd32768, 1'b1, 2, 1'b0);
      push_pair(16'sd12345, 16'sd0, 1'b1, 0, 1'b0);
      push_pair(16'sd1, 16'sd0, 1'b0, 0, 1'b0);
      push_pair(16'sd0, 16'sd1, 1'b1, 0, 1'b0);
      push_pair(16'sd3, 16'sd4, 1'b0, 0, 1'b0);
      push_pair(16'sd4, 16'sd3, 1'b1, 0, 1'b0);
      push_pair(16'sd5, -16'sd3, 1'b0, 3, 1'b0);
      push_pair(16'sd2, 16'sd7, 1'b1, 0, 1'b0);
      push_pair(16'sh5555, 16'shAAAA, 1'b0, 0, 1'b0);
      push_pair(16'shAAAA, 16'sh5555, 1'b1, 0, 1'b0);
      vectors_queued = 12;

      random_words = 0;
      drain_next   = 1'b0;
      while (random_words < RANDOM_WORDS) begin
         r = $urandom_range(0, 99);
         if (r < 50)
            len = $urandom_range(1, 4);
         else if (r < 85)
            len = $urandom_range(5, 16);
         else
            len = $urandom_range(17, 64);
         r = $urandom_range(0, 99);
         if (r < 35)
            shape = VEC_INDEP;
         else if (r < 50)
            shape = VEC_SAME;
         else if (r < 65)
            shape = VEC_OPPOSITE;
         else if (r < 85)
            shape = VEC_NEAR;
         else if (r < 93)
            shape = VEC_ZERO_A;
         else
            shape = VEC_ZERO_B;
         r = $urandom_range(0, 99);
         if (r < 40)
            kind = ELEM_FULL;
         else if (r < 65)
            kind = ELEM_SMALL;
         else if (r < 82)
            kind = ELEM_EXTREME;
         else if (r < 85)
            kind = ELEM_ZERO;
         else
            kind = ELEM_MIXED;
         burst = ($urandom_range(0, 4) == 0);
         add_vector(len, shape, kind, burst, drain_next);
         drain_next = (random_words < 200 && random_words + len >= 200) ||
                      (random_words < 420 && random_words + len >= 420);
         random_words += len;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pairs_pending.size() != 0 || offering || cosine_expected.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (cosine_expected.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, cosine_expected.size());
         fail_count++;
      end
      $display("%0d pair words in %0d vectors (directed corners plus random shapes)",
               words_sent, vectors_queued);
      $display("%0d results: %0d zero norm, %0d full scale, %0d mismatches",
               results_seen, zero_norm_seen, full_scale_seen, fail_count);
      if (fail_count == 0) begin
         $display("cosine_similarity_stream_top verification clean");
      end else begin
         $display("cosine_similarity_stream_top verification failed");
      end
      $finish;
   end

endmodule
